// ===== hdl/daily_relay_schedule_lookup_top_macros.svh =====
// Assertion macros shared by the schedule lookup RTL.
`ifndef DAILY_RELAY_SCHEDULE_LOOKUP_TOP_MACROS_SVH
`define DAILY_RELAY_SCHEDULE_LOOKUP_TOP_MACROS_SVH

// Check that a property holds at every clock edge outside reset.
`define DRSL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds outside reset.
`define DRSL_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ===== hdl/drsl_pkg.sv =====
// Types, constants and helpers for the daily relay schedule lookup.
package drsl_pkg;

  localparam int HOUR_W  = 5;
  localparam int MIN_W   = 6;
  localparam int VALUE_W = 8;
  localparam int KEY_W   = 12;
  localparam int CNT_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [KEY_W-1:0] TIME_SCALE = 12'd100;

  // Input opcodes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_EN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_VAL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COUNT     = 2'd2;

  typedef struct packed {
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [VALUE_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  // Time of day as hour*100 + minute
  function automatic logic [KEY_W-1:0] time_key(input logic [HOUR_W-1:0] h,
                                                input logic [MIN_W-1:0] m);
    logic [KEY_W-1:0] hk;
    hk = KEY_W'(h) * TIME_SCALE;
    return hk + KEY_W'(m);
  endfunction

endpackage

// ===== hdl/daily_relay_schedule_lookup_top.sv =====
// Top level of the daily relay schedule lookup: sequencer, registers, RAM.
//
// Usage:
//   Input channel (in_*): one transfer per item. in_opcode selects a table
//   write (entry_index/hour/minute/value) or a query (now_hour/now_minute).
//   Writes give no result. A query gives one result on
//   the out_* channel: relay value, inverted pin level, time of the chosen
//   entry and a valid flag.
//   Configuration channel (cfg_*): always ready; cfg_index selects force
//   enable, force value or entry count. Write it only while the block is idle.
// Query flow:
//   A query scans the table from the last entry in use down toward index 0,
//   one RAM read per cycle through the single time compare unit, and stops
//   at the first entry at or before the query time, else takes the last
//   entry in use; force mode and an empty table skip the scan. The block
//   takes no item while a query is in progress.
// Reset: configuration clears to zero and the sequencer returns to idle; the
//   table contents stay undefined until written.
// Stall: a result waits in the output register while out_ready is low;
//   writes are still taken, and a following query holds its result until
//   the output register drains.
`include "daily_relay_schedule_lookup_top_macros.svh"
module daily_relay_schedule_lookup_top #(
  parameter int MAX_ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // input channel
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            in_opcode,
  input  logic [3:0]                      in_entry_index,
  input  logic [drsl_pkg::HOUR_W-1:0]     in_entry_hour,
  input  logic [drsl_pkg::MIN_W-1:0]      in_entry_minute,
  input  logic [drsl_pkg::VALUE_W-1:0]    in_entry_value,
  input  logic [drsl_pkg::HOUR_W-1:0]     in_now_hour,
  input  logic [drsl_pkg::MIN_W-1:0]      in_now_minute,
  // result channel
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [drsl_pkg::VALUE_W-1:0]    out_relay_value,
  output logic                            out_pin_level,
  output logic [drsl_pkg::HOUR_W-1:0]     out_match_hour,
  output logic [drsl_pkg::MIN_W-1:0]      out_match_minute,
  output logic                            out_result_valid,
  // configuration channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [drsl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [drsl_pkg::CFG_DATA_W-1:0] cfg_data
);
  import drsl_pkg::*;

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

  // configuration registers
  logic               force_en_r;
  logic [VALUE_W-1:0] force_val_r;
  logic [CNT_W-1:0]   count_r;

  // sequencer and scan state
  state_t             state_r, state_nxt;
  logic [IDX_W-1:0]   scan_addr_r, scan_addr_nxt;
  logic               issue_done_r, issue_done_nxt;
  logic               start_r, start_nxt;
  logic               pend_r, pend_nxt;
  logic               pend_first_r, pend_first_nxt;
  logic               pend_last_r, pend_last_nxt;
  entry_t             wrap_r, wrap_nxt;
  logic [HOUR_W-1:0]  now_hour_r, now_hour_nxt;
  logic [MIN_W-1:0]   now_min_r, now_min_nxt;
  entry_t             res_r, res_nxt;
  logic               res_valid_r, res_valid_nxt;

  // output register
  logic               out_valid_r, out_valid_nxt;
  entry_t             out_ent_r, out_ent_nxt;
  logic               out_rv_r, out_rv_nxt;

  logic               in_xfer;
  logic               wr_en;
  logic [IDX_W-1:0]   last_idx;
  logic [ENTRY_W-1:0] rd_data;
  entry_t             rd_entry;
  entry_t             wr_entry;
  logic               hit;
  logic               out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign in_xfer   = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      force_en_r  <= 1'b0;
      force_val_r <= '0;
      count_r     <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_FORCE_EN:  force_en_r  <= cfg_data[0];
        CFG_FORCE_VAL: force_val_r <= cfg_data;
        CFG_COUNT:     count_r     <= cfg_data[CNT_W-1:0];
        default:       ;
      endcase
    end
  end

  // Last index in use, count saturated to the table depth
  always_comb begin
    if (32'(count_r) >= MAX_ENTRIES) begin
      last_idx = LAST_IDX;
    end else begin
      last_idx = IDX_W'(count_r - CNT_W'(1));
    end
  end

  // Table write from a write item; slots beyond the table are dropped
  assign wr_en    = in_xfer && (in_opcode == OP_WRITE) &&
                    (32'(in_entry_index) < MAX_ENTRIES);
  assign wr_entry = '{hour: in_entry_hour, minute: in_entry_minute, value: in_entry_value};

  drsl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (wr_en),
    .waddr (IDX_W'(in_entry_index)),
    .wdata (wr_entry),
    .raddr (scan_addr_r),
    .rdata (rd_data)
  );

  assign rd_entry = entry_t'(rd_data);

  drsl_key_cmp u_cmp (
    .now_hour    (now_hour_r),
    .now_minute  (now_min_r),
    .entry       (rd_entry),
    .at_or_after (hit)
  );

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    scan_addr_nxt  = scan_addr_r;
    issue_done_nxt = issue_done_r;
    start_nxt      = start_r;
    pend_nxt       = pend_r;
    pend_first_nxt = pend_first_r;
    pend_last_nxt  = pend_last_r;
    wrap_nxt       = wrap_r;
    now_hour_nxt   = now_hour_r;
    now_min_nxt    = now_min_r;
    res_nxt        = res_r;
    res_valid_nxt  = res_valid_r;
    out_valid_nxt  = out_valid_r;
    out_ent_nxt    = out_ent_r;
    out_rv_nxt     = out_rv_r;

    // drain the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_opcode == OP_QUERY)) begin
          now_hour_nxt = in_now_hour;
          now_min_nxt  = in_now_minute;
          if (force_en_r) begin
            res_nxt       = '{hour: '0, minute: '0, value: force_val_r};
            res_valid_nxt = 1'b1;
            state_nxt     = ST_DONE;
          end else if (count_r == '0) begin
            res_nxt       = '0;
            res_valid_nxt = 1'b0;
            state_nxt     = ST_DONE;
          end else begin
            scan_addr_nxt  = last_idx;
            issue_done_nxt = 1'b0;
            start_nxt      = 1'b1;
            pend_nxt       = 1'b0;
            state_nxt      = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        // issue the next read, highest index first
        if (!issue_done_r) begin
          pend_nxt       = 1'b1;
          pend_first_nxt = start_r;
          pend_last_nxt  = (scan_addr_r == '0);
          start_nxt      = 1'b0;
          if (scan_addr_r == '0) begin
            issue_done_nxt = 1'b1;
          end else begin
            scan_addr_nxt = scan_addr_r - IDX_W'(1);
          end
        end else begin
          pend_nxt = 1'b0;
        end
        // compare the entry that came back
        if (pend_r) begin
          if (pend_first_r) begin
            wrap_nxt = rd_entry;
          end
          if (hit) begin
            res_nxt       = rd_entry;
            res_valid_nxt = 1'b1;
            state_nxt     = ST_DONE;
          end else if (pend_last_r) begin
            // nothing earlier today: take the previous day's last point
            res_nxt       = pend_first_r ? rd_entry : wrap_r;
            res_valid_nxt = 1'b1;
            state_nxt     = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = res_r;
          out_rv_nxt    = res_valid_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      issue_done_r <= 1'b0;
      start_r      <= 1'b0;
      pend_r       <= 1'b0;
      pend_first_r <= 1'b0;
      pend_last_r  <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      issue_done_r <= issue_done_nxt;
      start_r      <= start_nxt;
      pend_r       <= pend_nxt;
      pend_first_r <= pend_first_nxt;
      pend_last_r  <= pend_last_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_addr_r <= scan_addr_nxt;
    wrap_r      <= wrap_nxt;
    now_hour_r  <= now_hour_nxt;
    now_min_r   <= now_min_nxt;
    res_r       <= res_nxt;
    res_valid_r <= res_valid_nxt;
    out_ent_r   <= out_ent_nxt;
    out_rv_r    <= out_rv_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_relay_value  = out_ent_r.value;
  assign out_pin_level    = (out_ent_r.value == '0);
  assign out_match_hour   = out_ent_r.hour;
  assign out_match_minute = out_ent_r.minute;
  assign out_result_valid = out_rv_r;

  // Checks
  `DRSL_ASSERT(a_scan_ends_on_last, (state_r == ST_SCAN && pend_r && pend_last_r) |=> (state_r == ST_DONE), "scan did not finish after index 0")
  `DRSL_ASSERT(a_done_loads_out, (state_r == ST_DONE && out_free) |=> (out_valid_r && state_r == ST_IDLE), "result not moved to output register")
  `DRSL_ASSERT(a_write_stays_idle, (in_xfer && in_opcode == OP_WRITE) |=> (state_r == ST_IDLE), "write item left the idle state")
  `DRSL_NEVER(a_scan_has_work, (state_r == ST_SCAN && !pend_r && issue_done_r), "scan stalled with no read in flight")

endmodule

// ===== hdl/drsl_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module drsl_ram #(
  parameter int WIDTH = 19,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/drsl_key_cmp.sv =====
// Shared time compare unit: is the query time at or after an entry's time.
module drsl_key_cmp (
  input  logic [drsl_pkg::HOUR_W-1:0] now_hour,
  input  logic [drsl_pkg::MIN_W-1:0]  now_minute,
  input  drsl_pkg::entry_t            entry,
  output logic                        at_or_after
);
  import drsl_pkg::*;

  logic [KEY_W-1:0] now_key;
  logic [KEY_W-1:0] entry_key;

  // Form both keys and compare
  assign now_key     = time_key(now_hour, now_minute);
  assign entry_key   = time_key(entry.hour, entry.minute);
  assign at_or_after = (now_key >= entry_key);

endmodule
